### hw/rtl/vdf_pkg.sv
// Package for the varint length packet deframer.
// Result item type, error codes, parser phase encoding and length constants.
// No dependencies.
package vdf_pkg;

  localparam int unsigned LenDigitBits = 7;
  localparam int unsigned LenPartBits  = 35;
  localparam int unsigned LenByteMax   = 4;
  localparam int unsigned ContBit      = 7;
  localparam logic [7:0]  DigitMask    = 8'h7F;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_ZERO_LEN  = 2'd1,
    ERR_TRUNC_PAY = 2'd2,
    ERR_TRUNC_LEN = 2'd3
  } err_kind_e;

  typedef enum logic [2:0] {
    PH_LEN  = 3'b001,
    PH_PAY  = 3'b010,
    PH_DROP = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
    err_kind_e  error_kind;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

endpackage

### hw/rtl/vdf_front.sv
// Front end of the deframer: accepts bytes, parses varint lengths and counts payload.
// Pushes result items into the queue. Depends on vdf_pkg.
module vdf_front
  import vdf_pkg::*;
#(
  parameter int unsigned LengthBits = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_end_i,
  input  logic       q_full_i,
  output logic       in_ready_o,
  output push_t      push_o
);

  phase_e                phase_q, phase_d;
  logic [LengthBits-1:0] accum_q, accum_d;
  logic [2:0]            cnt_q, cnt_d;
  logic [LengthBits-1:0] left_q, left_d;

  logic                  accept;
  logic [2:0]            cnt_sat;
  logic [5:0]            shamt;
  logic [LenPartBits-1:0] part;
  logic [LengthBits-1:0] accum_new;
  logic [LengthBits-1:0] left_m1;
  logic                  done;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign cnt_sat   = (cnt_q >= 3'(LenByteMax)) ? 3'(LenByteMax) : cnt_q;
  assign shamt     = 6'(cnt_sat) * 6'(LenDigitBits);
  assign part      = LenPartBits'(in_byte_i & DigitMask) << shamt;
  assign accum_new = accum_q | part[LengthBits-1:0];
  assign done      = !in_byte_i[ContBit] || (cnt_sat == 3'(LenByteMax));
  assign left_m1   = left_q - LengthBits'(1);

  always_comb begin
    phase_d = phase_q;
    accum_d = accum_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    push_o  = '0;
    push_o.res.error_kind = ERR_NONE;
    if (accept) begin
      case (phase_q)
        PH_LEN: begin
          accum_d = accum_new;
          if (!done) begin
            cnt_d = cnt_sat + 3'd1;
            if (in_end_i) begin
              push_o.valid          = 1'b1;
              push_o.res.error_kind = ERR_TRUNC_LEN;
            end
          end else begin
            cnt_d = '0;
            if (accum_new == '0) begin
              push_o.valid          = 1'b1;
              push_o.res.error_kind = ERR_ZERO_LEN;
              phase_d               = PH_DROP;
            end else if (in_end_i) begin
              push_o.valid          = 1'b1;
              push_o.res.error_kind = ERR_TRUNC_PAY;
            end else begin
              left_d  = accum_new;
              accum_d = '0;
              phase_d = PH_PAY;
            end
          end
        end
        PH_PAY: begin
          push_o.valid = 1'b1;
          if (left_m1 == '0) begin
            push_o.res.out_byte   = in_byte_i;
            push_o.res.packet_end = 1'b1;
            left_d                = '0;
            phase_d               = PH_LEN;
          end else if (in_end_i) begin
            push_o.res.error_kind = ERR_TRUNC_PAY;
          end else begin
            push_o.res.out_byte = in_byte_i;
            left_d              = left_m1;
          end
        end
        default: ;
      endcase
      if (in_end_i) begin
        phase_d = PH_LEN;
        accum_d = '0;
        cnt_d   = '0;
        left_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN;
      accum_q <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
    end
  end

  // payload phase always has bytes still due
  a_pay_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAY |-> left_q != '0)
    else $error("payload phase with zero bytes left");

  // end of buffer returns the parser to its reset state
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_end_i |=> phase_q == PH_LEN && accum_q == '0 && cnt_q == '0)
    else $error("parser not cleared after buffer end");

endmodule

### hw/rtl/vdf_queue.sv
// Short result queue between the deframer front end and the output stage.
// Register-based FIFO of res_t items. Depends on vdf_pkg.
module vdf_queue
  import vdf_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  nonempty_o,
  output res_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];
  assign do_push    = push_i.valid && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.res;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o)
    else $error("result pushed into full queue");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count out of range");

endmodule

### hw/rtl/vdf_back.sv
// Output stage of the deframer: drains the result queue into a registered stream port.
// Depends on vdf_pkg.
module vdf_back
  import vdf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_nonempty_i,
  input  res_t q_head_i,
  output logic q_pop_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  output res_t out_res_o
);

  logic out_valid_q;
  res_t out_res_q;

  assign q_pop_o     = q_nonempty_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_res_q <= q_head_i;
    end
  end

endmodule

### hw/rtl/varint_length_packet_deframer.sv
// Varint length packet deframer: one byte accepted per cycle while the queue has room.
// A result passes through a queue entry, then the output register, before it is
// valid on the output.
// Throughput: one byte per cycle; the front end stalls only when the result
// queue is full, which happens only while the output side is held off.
// Reset (rst_ni low, async) clears parser phase, length, counters and queue.
// Depends on vdf_pkg, vdf_front, vdf_queue, vdf_back.
module varint_length_packet_deframer
  import vdf_pkg::*;
#(
  parameter int unsigned LengthBits = 32,
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // buffer_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // packet_end
  output logic [1:0] m_axis_tuser    // [1:0] error_kind
);

  push_t push;
  logic  q_full, q_nonempty, q_pop;
  res_t  q_head, out_res;

  vdf_front #(
    .LengthBits(LengthBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_end_i   (s_axis_tlast),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready),
    .push_o     (push)
  );

  vdf_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (q_pop),
    .full_o     (q_full),
    .nonempty_o (q_nonempty),
    .head_o     (q_head)
  );

  vdf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_nonempty_i (q_nonempty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_res_o    (out_res)
  );

  assign m_axis_tdata = out_res.out_byte;
  assign m_axis_tlast = out_res.packet_end;
  assign m_axis_tuser = out_res.error_kind;

endmodule
